// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the point light slot binder.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/plsb_pkg.sv -----
// Shared constants, codes and types of the point light slot binder.
// Used by plsb_lane and point_light_slot_binder; depends on nothing.
package plsb_pkg;

    localparam int MAX_SLOTS     = 7;
    localparam int DIR_LENGTH    = 120;

    localparam int SLOT_W        = 3;
    localparam int KIND_W        = 2;
    localparam int COORD_W       = 16;
    localparam int OBJ_W         = 20;
    localparam int FRAC_W        = 4;
    localparam int COL_W         = 8;
    localparam int DIR_W         = 8;
    localparam int MAG_W         = 20;
    localparam int SQ_W          = 2 * MAG_W;
    localparam int D2_W          = SQ_W + 2;
    localparam int PREC_W        = 39;
    localparam int RSQ_W         = 2 * COORD_W;
    localparam int COL_DIV_STEPS = COL_W;
    localparam int NEAR_LIMIT    = 256;

    localparam logic [KIND_W-1:0] KIND_POINT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIR   = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_CHECK,
        ST_MULT,
        ST_COLOR_DIV,
        ST_DIR_LOAD,
        ST_DIR_DIV,
        ST_ROOT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        LOP_HOLD,
        LOP_LOAD,
        LOP_SQUARE,
        LOP_PREP,
        LOP_COLOR_LOAD,
        LOP_DIV_STEP,
        LOP_DIR_LOAD,
        LOP_ROOT_STEP
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        logic     near;
        logic     is_dir;
    } lane_ctl_t;

endpackage

// ----- rtl/core/plsb_lane.sv -----
// One axis lane of the point light slot binder: difference, square, and a
// restoring divider and square root stepped one digit per cycle. Uses plsb_pkg.
module plsb_lane #(
    parameter int DIR_LENGTH = plsb_pkg::DIR_LENGTH
) (
    input  logic                                   clk,
    input  plsb_pkg::lane_ctl_t                    ctl,
    input  logic signed [plsb_pkg::COORD_W-1:0]    light,
    input  logic signed [plsb_pkg::OBJ_W-1:0]      obj,
    input  logic        [plsb_pkg::COL_W-1:0]      color_in,
    input  logic        [plsb_pkg::PREC_W-1:0]     diff,
    input  logic        [plsb_pkg::PREC_W-1:0]     r2,
    input  logic        [plsb_pkg::PREC_W-1:0]     d2,
    output logic        [plsb_pkg::SQ_W-1:0]       sq,
    output logic        [plsb_pkg::COL_W-1:0]      color_out,
    output logic signed [plsb_pkg::DIR_W-1:0]      dir_out
);
    import plsb_pkg::*;

    localparam int QW    = $clog2(DIR_LENGTH * DIR_LENGTH + 1);
    localparam int RW    = $clog2(DIR_LENGTH + 1);
    localparam int QUO_W = (QW > COL_W) ? QW : COL_W;
    localparam int NUM_W = PREC_W + QUO_W;
    localparam int CMP_W = 2 * RW + QW;
    localparam int NP_W  = RW + FRAC_W;
    localparam logic [QW-1:0] DL_SQ = QW'(DIR_LENGTH * DIR_LENGTH);
    localparam logic [RW-1:0] DL    = RW'(DIR_LENGTH);

    logic signed [MAG_W:0]  delta;
    logic        [MAG_W:0]  delta_abs;
    logic        [MAG_W-1:0] mag_reg;
    logic                   neg_reg;
    logic        [DIR_W-1:0] byte_reg;
    logic        [COL_W-1:0] col_in_reg;
    logic        [COL_W-1:0] col_reg;
    logic        [SQ_W-1:0]  sq_reg;
    logic        [NUM_W-1:0] dnum_reg;
    logic        [NUM_W-1:0] rem_reg;
    logic        [NUM_W-1:0] dv_reg;
    logic        [QUO_W-1:0] quo_reg;
    logic        [RW-1:0]    root_reg;
    logic        [RW-1:0]    mask_reg;
    logic                   fits;
    logic        [RW-1:0]    trial;
    logic        [CMP_W-1:0] trial_sq;
    logic        [NP_W-1:0]  near_prod;
    logic        [RW-1:0]    qmag;
    logic        [DIR_W-1:0] qmag_ext;

    assign delta     = {light[COORD_W-1], light, {FRAC_W{1'b0}}} - {obj[OBJ_W-1], obj};
    assign delta_abs = delta[MAG_W] ? (~delta + 1'b1) : delta;
    assign fits      = (rem_reg >= dv_reg);
    assign trial     = root_reg | mask_reg;
    assign trial_sq  = CMP_W'(trial) * CMP_W'(trial);

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            LOP_LOAD:
            begin
                mag_reg    <= delta_abs[MAG_W-1:0];
                neg_reg    <= delta[MAG_W];
                byte_reg   <= light[DIR_W-1:0];
                col_in_reg <= color_in;
            end
            LOP_SQUARE:
            begin
                sq_reg <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
            end
            LOP_PREP:
            begin
                dnum_reg <= NUM_W'(DL_SQ) * NUM_W'(sq_reg[PREC_W-1:0]);
            end
            LOP_COLOR_LOAD:
            begin
                rem_reg <= NUM_W'(col_in_reg) * NUM_W'(diff);
                dv_reg  <= NUM_W'(r2) << (COL_W - 1);
                quo_reg <= '0;
            end
            LOP_DIV_STEP:
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - dv_reg;
                end
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                dv_reg  <= dv_reg >> 1;
            end
            LOP_DIR_LOAD:
            begin
                col_reg  <= quo_reg[COL_W-1:0];
                rem_reg  <= dnum_reg;
                dv_reg   <= NUM_W'(d2) << (QW - 1);
                quo_reg  <= '0;
                root_reg <= '0;
                mask_reg <= RW'(1) << (RW - 1);
            end
            LOP_ROOT_STEP:
            begin
                if (trial_sq <= CMP_W'(quo_reg[QW-1:0]))
                begin
                    root_reg <= trial;
                end
                mask_reg <= mask_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

    assign near_prod = NP_W'(mag_reg[FRAC_W-1:0]) * NP_W'(DL);
    assign qmag      = ctl.near ? near_prod[NP_W-1:FRAC_W] : root_reg;
    assign qmag_ext  = DIR_W'(qmag);

    assign sq        = sq_reg;
    assign color_out = ctl.is_dir ? col_in_reg : col_reg;
    assign dir_out   = ctl.is_dir ? byte_reg : (neg_reg ? (~qmag_ext + 1'b1) : qmag_ext);

endmodule

// ----- rtl/core/point_light_slot_binder.sv -----
// Top level of the point light slot binder: sequencer, slot count and result
// register. Depends on plsb_pkg, plsb_lane and assert_macros.svh.
//
// Each item carries one light and the object position. A point light that lies
// strictly inside its radius, or any directional light, takes the next free slot
// of a group of MAX_SLOTS slots; a point light's color is scaled by
// (r^2 - d^2) / r^2 and its direction is the difference vector scaled to
// DIR_LENGTH / d, both truncated, or scaled by DIR_LENGTH alone when the squared
// distance is below NEAR_LIMIT. A directional light passes its color through and
// takes the low bytes of its position as direction. One item is handled at a
// time, while the previous result may still wait in the output register. The
// restoring divider and root steps of the axis lanes retire one digit per cycle.
// A new_group item empties the group before it is handled.
`include "assert_macros.svh"

module point_light_slot_binder #(
    parameter int DIR_LENGTH = plsb_pkg::DIR_LENGTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic        [plsb_pkg::KIND_W-1:0]  light_kind,
    input  logic                                new_group,
    input  logic signed [plsb_pkg::COORD_W-1:0] light_x,
    input  logic signed [plsb_pkg::COORD_W-1:0] light_y,
    input  logic signed [plsb_pkg::COORD_W-1:0] light_z,
    input  logic        [plsb_pkg::COL_W-1:0]   red_in,
    input  logic        [plsb_pkg::COL_W-1:0]   green_in,
    input  logic        [plsb_pkg::COL_W-1:0]   blue_in,
    input  logic signed [plsb_pkg::COORD_W-1:0] light_radius,
    input  logic signed [plsb_pkg::OBJ_W-1:0]   object_x,
    input  logic signed [plsb_pkg::OBJ_W-1:0]   object_y,
    input  logic signed [plsb_pkg::OBJ_W-1:0]   object_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                bound,
    output logic                                slots_full,
    output logic        [plsb_pkg::SLOT_W-1:0]  slot_index,
    output logic        [plsb_pkg::COL_W-1:0]   red_out,
    output logic        [plsb_pkg::COL_W-1:0]   green_out,
    output logic        [plsb_pkg::COL_W-1:0]   blue_out,
    output logic signed [plsb_pkg::DIR_W-1:0]   dir_x,
    output logic signed [plsb_pkg::DIR_W-1:0]   dir_y,
    output logic signed [plsb_pkg::DIR_W-1:0]   dir_z
);
    import plsb_pkg::*;

    localparam int QW        = $clog2(DIR_LENGTH * DIR_LENGTH + 1);
    localparam int RW        = $clog2(DIR_LENGTH + 1);
    localparam int MAX_STEPS = (QW > COL_DIV_STEPS) ? QW : COL_DIV_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS);

    state_t                 state_reg;
    state_t                 state_next;
    lane_ctl_t              lane_ctl;
    logic                   accept;
    logic                   load_out;
    logic                   qual_point;
    logic                   qualifies;
    logic                   group_full;
    logic                   take;

    logic [SLOT_W-1:0]      slots_reg;
    logic                   out_valid_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [KIND_W-1:0]      kind_reg;
    logic [COORD_W-1:0]     rmag_reg;
    logic [PREC_W-1:0]      r2_reg;
    logic [D2_W-1:0]        d2_reg;
    logic [PREC_W-1:0]      diff_reg;
    logic                   near_reg;
    logic                   bound_reg;
    logic                   full_reg;
    logic [SLOT_W-1:0]      idx_reg;
    logic [COORD_W-1:0]     rmag_in;
    logic [RSQ_W-1:0]       rsq;

    logic                   res_bound_reg;
    logic                   res_full_reg;
    logic [SLOT_W-1:0]      res_idx_reg;
    logic [COL_W-1:0]       res_col_reg [3];
    logic [DIR_W-1:0]       res_dir_reg [3];

    logic [SQ_W-1:0]        lane_sq  [3];
    logic [COL_W-1:0]       lane_col [3];
    logic [DIR_W-1:0]       lane_dir [3];

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign load_out   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign qual_point = (d2_reg < D2_W'(r2_reg));
    assign qualifies  = (kind_reg == KIND_DIR) || ((kind_reg == KIND_POINT) && qual_point);
    assign group_full = (slots_reg >= SLOT_W'(MAX_SLOTS));
    assign take       = qualifies && !group_full;
    assign rmag_in    = light_radius[COORD_W-1] ? (~light_radius + 1'b1) : light_radius;
    assign rsq        = RSQ_W'(rmag_reg) * RSQ_W'(rmag_reg);

    plsb_lane #(.DIR_LENGTH(DIR_LENGTH)) u_lane_x (
        .clk       (clk),
        .ctl       (lane_ctl),
        .light     (light_x),
        .obj       (object_x),
        .color_in  (red_in),
        .diff      (diff_reg),
        .r2        (r2_reg),
        .d2        (d2_reg[PREC_W-1:0]),
        .sq        (lane_sq[0]),
        .color_out (lane_col[0]),
        .dir_out   (lane_dir[0])
    );

    plsb_lane #(.DIR_LENGTH(DIR_LENGTH)) u_lane_y (
        .clk       (clk),
        .ctl       (lane_ctl),
        .light     (light_y),
        .obj       (object_y),
        .color_in  (green_in),
        .diff      (diff_reg),
        .r2        (r2_reg),
        .d2        (d2_reg[PREC_W-1:0]),
        .sq        (lane_sq[1]),
        .color_out (lane_col[1]),
        .dir_out   (lane_dir[1])
    );

    plsb_lane #(.DIR_LENGTH(DIR_LENGTH)) u_lane_z (
        .clk       (clk),
        .ctl       (lane_ctl),
        .light     (light_z),
        .obj       (object_z),
        .color_in  (blue_in),
        .diff      (diff_reg),
        .r2        (r2_reg),
        .d2        (d2_reg[PREC_W-1:0]),
        .sq        (lane_sq[2]),
        .color_out (lane_col[2]),
        .dir_out   (lane_dir[2])
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        lane_ctl.op   = LOP_HOLD;
        lane_ctl.near = near_reg;
        lane_ctl.is_dir = (kind_reg == KIND_DIR);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    lane_ctl.op = LOP_LOAD;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                lane_ctl.op = LOP_SQUARE;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                lane_ctl.op = LOP_PREP;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (take && (kind_reg == KIND_POINT))
                begin
                    state_next = ST_MULT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MULT:
            begin
                lane_ctl.op = LOP_COLOR_LOAD;
                state_next  = ST_COLOR_DIV;
            end
            ST_COLOR_DIV:
            begin
                lane_ctl.op = LOP_DIV_STEP;
                if (cnt_reg == CNT_W'(COL_DIV_STEPS - 1))
                begin
                    state_next = ST_DIR_LOAD;
                end
            end
            ST_DIR_LOAD:
            begin
                lane_ctl.op = LOP_DIR_LOAD;
                state_next  = ST_DIR_DIV;
            end
            ST_DIR_DIV:
            begin
                lane_ctl.op = LOP_DIV_STEP;
                if (cnt_reg == CNT_W'(QW - 1))
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                lane_ctl.op = LOP_ROOT_STEP;
                if (cnt_reg == CNT_W'(RW - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && new_group)
            begin
                slots_reg <= '0;
            end
            else if ((state_reg == ST_CHECK) && take)
            begin
                slots_reg <= slots_reg + 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_reg <= light_kind;
                    rmag_reg <= rmag_in;
                end
            end
            ST_SQUARE:
            begin
                r2_reg <= PREC_W'({rsq, 8'h00});
            end
            ST_SUM:
            begin
                d2_reg <= D2_W'(lane_sq[0]) + D2_W'(lane_sq[1]) + D2_W'(lane_sq[2]);
            end
            ST_CHECK:
            begin
                near_reg  <= (d2_reg < D2_W'(NEAR_LIMIT));
                diff_reg  <= r2_reg - d2_reg[PREC_W-1:0];
                bound_reg <= take;
                full_reg  <= qualifies && group_full;
                idx_reg   <= take ? slots_reg : '0;
            end
            ST_MULT, ST_DIR_LOAD:
            begin
                cnt_reg <= '0;
            end
            ST_COLOR_DIV:
            begin
                cnt_reg <= (cnt_reg == CNT_W'(COL_DIV_STEPS - 1)) ? '0 : cnt_reg + 1'b1;
            end
            ST_DIR_DIV:
            begin
                cnt_reg <= (cnt_reg == CNT_W'(QW - 1)) ? '0 : cnt_reg + 1'b1;
            end
            ST_ROOT:
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    res_bound_reg <= bound_reg;
                    res_full_reg  <= full_reg;
                    res_idx_reg   <= idx_reg;
                    for (int i = 0; i < 3; i++)
                    begin
                        res_col_reg[i] <= bound_reg ? lane_col[i] : '0;
                        res_dir_reg[i] <= bound_reg ? lane_dir[i] : '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign bound      = res_bound_reg;
    assign slots_full = res_full_reg;
    assign slot_index = res_idx_reg;
    assign red_out    = res_col_reg[0];
    assign green_out  = res_col_reg[1];
    assign blue_out   = res_col_reg[2];
    assign dir_x      = res_dir_reg[0];
    assign dir_y      = res_dir_reg[1];
    assign dir_z      = res_dir_reg[2];

    `ASSERT_CLK(a_slots_in_range, slots_reg <= SLOT_W'(MAX_SLOTS), "slot count beyond group size")
    `ASSERT_IMPLY(a_bound_xor_full, out_valid, !(bound && slots_full), "item both bound and full")
    `ASSERT_IMPLY(a_unbound_zero, out_valid && !bound,
        (slot_index == '0) && (red_out == '0) && (dir_x == '0), "unbound item has nonzero fields")
    `ASSERT_IMPLY(a_accept_starts, accept, ##1 (state_reg == ST_SQUARE),
        "accepted item did not start")

endmodule
